>>> rtl/core/ipwcr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the IR pulse-width capture and replay unit.
// No dependencies.
package ipwcr_pkg;

    localparam int RUN_DEPTH_DEF  = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam int          TIMEOUT_W     = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam int          SEG_W         = 11;

    // Opcodes of a request
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_REPLAY  = 2'd2;

    // Engine modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_CAPTURE = 2'd1;
    localparam logic [1:0] MODE_REPLAY  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic       level;
    } t_in_req;

    typedef struct packed {
        logic             carrier_on;
        logic [1:0]       mode;
        logic [SEG_W-1:0] segments;
        logic             overflow;
        logic             done_res;
    } t_out_res;

endpackage

>>> rtl/core/ipwcr_run_store.sv
`timescale 1ns / 1ps
// Run store: one write port, one registered read port with write forwarding.
// No package dependencies.
module ipwcr_run_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // forward a same-cycle write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ipwcr_engine.sv
`timescale 1ns / 1ps
// Capture/replay control: counters, indexes, mode and carrier; drives the run store.
// Depends on ipwcr_pkg.
module ipwcr_engine #(
    parameter int RUN_DEPTH  = 1024,
    parameter int COUNT_BITS = 16,
    parameter int AW         = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  ipwcr_pkg::t_in_req             i_req,
    input  logic                           i_cfg_we,
    input  logic [ipwcr_pkg::TIMEOUT_W-1:0] i_cfg_wdata,
    input  logic [COUNT_BITS-1:0]          i_rd_data,
    output logic                           o_we,
    output logic [AW-1:0]                  o_waddr,
    output logic [COUNT_BITS-1:0]          o_wdata,
    output logic [AW-1:0]                  o_raddr,
    output ipwcr_pkg::t_out_res            o_res
);
    import ipwcr_pkg::*;

    localparam int IW = $clog2(RUN_DEPTH + 1);
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
    localparam logic [IW-1:0] IDX_FULL = IW'(RUN_DEPTH);

    logic [TIMEOUT_W-1:0] r_timeout;
    logic [1:0]           r_mode,    n_mode;
    logic                 r_prev,    n_prev;
    logic [CW-1:0]        r_cnt,     n_cnt;
    logic [IW-1:0]        r_wr_idx,  n_wr_idx;
    logic [IW-1:0]        r_rd_idx,  n_rd_idx;
    logic [CW-1:0]        r_hold,    n_hold;
    logic                 r_carrier, n_carrier;
    logic                 r_ovf,     n_ovf;

    logic          done;
    logic [CW-1:0] cnt_inc;
    logic [32:0]   cnt_ext;
    logic [32:0]   tmo_ext;
    logic [IW-1:0] wr_inc;
    logic [31:0]   wr_ext;

    assign cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign cnt_ext = 33'(cnt_inc);
    assign tmo_ext = 33'(r_timeout);
    assign wr_inc  = r_wr_idx + 1'b1;

    always_comb begin
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_cnt     = r_cnt;
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_hold    = r_hold;
        n_carrier = r_carrier;
        n_ovf     = r_ovf;
        done      = 1'b0;
        o_we      = 1'b0;
        if (i_accept) begin
            priority if (i_req.opcode == OP_CAPTURE) begin
                n_mode    = MODE_CAPTURE;
                n_prev    = i_req.level;
                n_cnt     = CW'(1);
                n_wr_idx  = '0;
                n_rd_idx  = '0;
                n_hold    = '0;
                n_ovf     = 1'b0;
                n_carrier = 1'b0;
            end else if (i_req.opcode == OP_REPLAY) begin
                n_mode    = MODE_REPLAY;
                n_rd_idx  = '0;
                n_hold    = '0;
                n_carrier = 1'b0;
                if (r_wr_idx == '0) begin
                    n_mode = MODE_IDLE;
                    done   = 1'b1;
                end
            end else if (r_mode == MODE_CAPTURE) begin
                if (i_req.level != r_prev) begin
                    // close the run and store it
                    o_we     = 1'b1;
                    n_wr_idx = wr_inc;
                    n_prev   = i_req.level;
                    n_cnt    = CW'(1);
                    if (wr_inc == IDX_FULL) begin
                        n_ovf  = 1'b1;
                        n_mode = MODE_IDLE;
                        done   = 1'b1;
                    end
                end else begin
                    n_cnt = cnt_inc;
                    if ((cnt_ext >= tmo_ext) || (cnt_inc == CNT_MAX)) begin
                        n_mode = MODE_IDLE;
                        done   = 1'b1;
                    end
                end
            end else if (r_mode == MODE_REPLAY) begin
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end else if (r_rd_idx < r_wr_idx) begin
                    // prefetched entry at the read index is on i_rd_data
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_carrier = ~r_carrier;
                    n_hold    = (i_rd_data == '0) ? '0 : i_rd_data - 1'b1;
                end else begin
                    n_carrier = 1'b0;
                    n_mode    = MODE_IDLE;
                    done      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_mode    <= MODE_IDLE;
            r_prev    <= 1'b0;
            r_cnt     <= '0;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_hold    <= '0;
            r_carrier <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_cnt     <= n_cnt;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_hold    <= n_hold;
            r_carrier <= n_carrier;
            r_ovf     <= n_ovf;
        end
    end

    assign o_waddr = r_wr_idx[AW-1:0];
    assign o_wdata = r_cnt;
    assign o_raddr = n_rd_idx[AW-1:0];

    assign wr_ext = 32'(n_wr_idx);

    assign o_res.carrier_on = n_carrier;
    assign o_res.mode       = n_mode;
    assign o_res.segments   = wr_ext[SEG_W-1:0];
    assign o_res.overflow   = n_ovf;
    assign o_res.done_res   = done;

endmodule

>>> rtl/core/ipwcr_out_buf.sv
`timescale 1ns / 1ps
// Output register with a skid stage for the result channel.
// Depends on ipwcr_pkg.
module ipwcr_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ipwcr_pkg::t_out_res i_res,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output ipwcr_pkg::t_out_res o_res
);
    import ipwcr_pkg::*;

    logic     r_out_valid;
    t_out_res r_out_res;
    logic     r_skid_valid;
    t_out_res r_skid_res;
    logic     pop;

    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out_res <= r_skid_valid ? r_skid_res : i_res;
        end else if (i_push) begin
            r_skid_res <= i_res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;

endmodule

>>> rtl/core/ir_pulse_width_capture_replay_unit.sv
`timescale 1ns / 1ps
// Top level of the IR pulse-width capture and replay unit.
// Depends on ipwcr_pkg, ipwcr_run_store, ipwcr_engine and ipwcr_out_buf.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) carries one request per
//   sample tick: a tick with the sampled receiver level, a capture start or a
//   replay start. Output channel (o_out_valid / i_out_stall / o_out_res) returns
//   exactly one result per request: carrier enable, mode, stored run count,
//   overflow flag and a done pulse.
//   Each result is registered and shown the cycle after accept if the output
//   register is free; a result in the skid stage waits behind the one ahead.
//   Throughput: one request per cycle while o_in_stall is low. The run store
//   has one read port; the entry at the current read index is prefetched every
//   cycle, so a run load during replay does not hold up requests. Writes to the
//   entry being read are forwarded into the read register.
//   Stall: a two-deep result buffer (output register plus skid stage) sits
//   between the engine and the receiver; o_in_stall rises only when both are
//   full, so a stalled output does not block the input while the skid is free.
//   Reset (synchronous, active low): mode idle, carrier off, counts and flags
//   clear, idle_timeout back to 5000. The run store is not cleared; no
//   clearing pass runs, and requests are accepted right after reset.
//   i_cfg_we writes idle_timeout; write it only while the unit is idle.
module ir_pulse_width_capture_replay_unit #(
    parameter int RUN_DEPTH  = ipwcr_pkg::RUN_DEPTH_DEF,
    parameter int COUNT_BITS = ipwcr_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ipwcr_pkg::t_in_req              i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ipwcr_pkg::t_out_res             o_out_res,
    input  logic                            i_cfg_we,
    input  logic [ipwcr_pkg::TIMEOUT_W-1:0] i_cfg_wdata
);
    import ipwcr_pkg::*;

    localparam int AW = $clog2(RUN_DEPTH);

    logic                  accept;
    logic                  st_we;
    logic [AW-1:0]         st_waddr;
    logic [COUNT_BITS-1:0] st_wdata;
    logic [AW-1:0]         st_raddr;
    logic [COUNT_BITS-1:0] st_rdata;
    t_out_res              eng_res;
    logic                  buf_full;

    // take a request whenever the result buffer has room
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    ipwcr_run_store #(
        .DEPTH (RUN_DEPTH),
        .WIDTH (COUNT_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ipwcr_engine #(
        .RUN_DEPTH  (RUN_DEPTH),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rd_data   (st_rdata),
        .o_we        (st_we),
        .o_waddr     (st_waddr),
        .o_wdata     (st_wdata),
        .o_raddr     (st_raddr),
        .o_res       (eng_res)
    );

    ipwcr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (eng_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out_res)
    );

    // after an accepted request the output always holds a valid result on the next cycle
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // a finishing request leaves the unit idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.done_res) |-> (o_out_res.mode == MODE_IDLE))
        else $error("done pulse while not idle");

    // the carrier is only driven during replay
    a_carrier_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.carrier_on) |-> (o_out_res.mode == MODE_REPLAY))
        else $error("carrier on outside replay");

endmodule
